/* rtl/core/povw_pkg.sv */
// Package for the per-object vertex weld block.
// Holds payload structs, status codes, controller states and fixed widths.
// No dependencies.
package povw_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned THR_W    = 52;

  localparam logic [THR_W-1:0] THR_RESET = 52'd100;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REAPPEAR = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic                      first_corner;
    logic [ID_W-1:0]           object_id;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } corner_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        vertex_index;
    logic                      is_new;
    status_e                   status;
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic signed [COORD_W-1:0] vert_z;
  } result_t;

endpackage

/* rtl/core/povw_corner_if.sv */
// Input channel of the vertex weld block: one triangle corner per beat.
// Depends on povw_pkg.
interface povw_corner_if import povw_pkg::*; ();
  logic    valid;
  logic    ready;
  corner_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/povw_result_if.sv */
// Output channel of the vertex weld block: one weld result per beat.
// Depends on povw_pkg.
interface povw_result_if import povw_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/per_object_vertex_weld_top.sv */
// Top level of the per-object vertex weld block: controller, vertex memory,
// object flag memory and counters. Depends on povw_pkg, povw_corner_if,
// povw_result_if and povw_dist.
//
//   channel   | dir | beat
//   corner_i  | in  | first_corner, object_id, pos_x/y/z
//   result_o  | out | vertex_index, is_new, status, vert_x/y/z
//   cfg_*     | in  | merge threshold write, no read-back
//
// When no stored vertex matches, the N vertices of the current object (at most
// MAX_OBJECT_VERTICES) are read in turn, one read per cycle, and the read register and two
// distance stages then drain before the result is registered; a match at entry i ends the
// scan early, and a reappearing id skips the scan.
// A first corner adds a pass over min(MAX_OBJECTS, 256) entries that clears the object flags;
// the same pass runs after reset with the input held off.
// The next corner is taken in the idle step after a result is registered; hold the final step
// while the output register is full.
module per_object_vertex_weld_top import povw_pkg::*; #(
  parameter int unsigned MAX_OBJECT_VERTICES = 1024,
  parameter int unsigned MAX_VERTICES        = 65536,
  parameter int unsigned MAX_OBJECTS         = 256,
  parameter int unsigned COORD_BITS          = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  povw_corner_if.sink      corner_i,
  povw_result_if.source    result_o
);

  localparam int unsigned CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int unsigned AW    = $clog2(MAX_OBJECT_VERTICES);
  localparam int unsigned OCW   = $clog2(MAX_OBJECT_VERTICES + 1);
  localparam int unsigned TW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned NSEEN = (MAX_OBJECTS < 256) ? MAX_OBJECTS : 256;
  localparam int unsigned SW    = $clog2(NSEEN);
  localparam int unsigned IXA   = (TW > OCW) ? TW : OCW;
  localparam int unsigned IXW   = (IXA > INDEX_W) ? IXA : INDEX_W;

  state_e            state_q, state_d;
  logic [THR_W-1:0]  thr_q;
  logic              seen_rd_q;
  logic [SW-1:0]     clr_q;
  logic              init_q;
  logic [ID_W-1:0]   cur_q;
  logic [OCW-1:0]    cnt_q;
  logic [TW-1:0]     base_q, tot_q;
  logic              first_q;
  logic [ID_W-1:0]   id_q;
  logic [CW-1:0]     cx_q, cy_q, cz_q;
  logic [OCW-1:0]    rd_idx_q;
  logic              v1_q;
  logic [OCW-1:0]    idx1_q;
  logic [3*CW-1:0]   rd_data_q;
  logic              reap_q, hit_q;
  logic [OCW-1:0]    hit_idx_q;
  logic [3*CW-1:0]   hit_vert_q;
  logic              out_valid_q;
  result_t           out_q, out_d;

  logic [3*CW-1:0]   mem [MAX_OBJECT_VERTICES];
  logic              seen_mem [NSEEN];

  logic              accept, out_free, id_seen, chk_reap, cur_ok, full;
  logic              rd_en, scan_done, wr_en, finish, clr_last, seen_we;
  logic              d_hit, d_busy;
  logic [OCW-1:0]    d_idx;
  logic [3*CW-1:0]   d_vert;
  logic [IXW-1:0]    hit_sum, new_idx;
  logic signed [CW-1:0] hx, hy, hz, nx, ny, nz;

  assign accept   = corner_i.valid && corner_i.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign id_seen  = (32'(id_q) < 32'(MAX_OBJECTS)) && seen_rd_q;
  assign chk_reap = !first_q && (id_q != cur_q) && id_seen;
  assign cur_ok   = 32'(cur_q) < 32'(MAX_OBJECTS);
  assign full     = (cnt_q >= OCW'(MAX_OBJECT_VERTICES)) || (tot_q >= TW'(MAX_VERTICES));
  assign clr_last = (clr_q == SW'(NSEEN - 1));
  assign seen_we  = finish && !reap_q && (hit_q || !full) && cur_ok;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_last) state_d = init_q ? S_IDLE : S_SCAN;
      S_IDLE:   if (corner_i.valid) state_d = S_CHECK;
      S_CHECK: begin
        if (chk_reap) state_d = S_FINISH;
        else if (first_q) state_d = S_CLEAR;
        else state_d = S_SCAN;
      end
      S_SCAN:   if (d_hit || scan_done) state_d = S_FINISH;
      S_FINISH: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    corner_i.ready = 1'b0;
    rd_en          = 1'b0;
    scan_done      = 1'b0;
    finish         = 1'b0;
    wr_en          = 1'b0;
    case (state_q)
      S_IDLE:   corner_i.ready = 1'b1;
      S_SCAN: begin
        rd_en     = !d_hit && (rd_idx_q < cnt_q);
        scan_done = !d_hit && (rd_idx_q >= cnt_q) && !v1_q && !d_busy;
      end
      S_FINISH: begin
        finish = out_free;
        wr_en  = out_free && !reap_q && !hit_q && !full;
      end
      default: ;
    endcase
  end

  povw_dist #(
    .CW (CW),
    .IW (OCW)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flush_i    (d_hit),
    .in_valid_i (v1_q && !d_hit),
    .in_idx_i   (idx1_q),
    .vert_i     (rd_data_q),
    .corner_i   ({cx_q, cy_q, cz_q}),
    .thr_i      (thr_q),
    .hit_o      (d_hit),
    .hit_idx_o  (d_idx),
    .hit_vert_o (d_vert),
    .busy_o     (d_busy)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= {cx_q, cy_q, cz_q};
    end
    rd_data_q <= mem[rd_idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      seen_mem[clr_q] <= 1'b0;
    end else if (seen_we) begin
      seen_mem[cur_q[SW-1:0]] <= 1'b1;
    end
    if (accept) begin
      seen_rd_q <= seen_mem[corner_i.data.object_id[SW-1:0]];
    end
  end

  // Result assembly
  assign hit_sum = IXW'(base_q) + IXW'(hit_idx_q);
  assign new_idx = IXW'(tot_q);
  assign hx = hit_vert_q[3*CW-1 -: CW];
  assign hy = hit_vert_q[2*CW-1 -: CW];
  assign hz = hit_vert_q[CW-1 -: CW];
  assign nx = cx_q;
  assign ny = cy_q;
  assign nz = cz_q;

  always_comb begin
    out_d = '0;
    if (reap_q) begin
      out_d.status = ST_REAPPEAR;
    end else if (hit_q) begin
      out_d.status       = ST_OK;
      out_d.vertex_index = hit_sum[INDEX_W-1:0];
      out_d.vert_x       = COORD_W'(hx);
      out_d.vert_y       = COORD_W'(hy);
      out_d.vert_z       = COORD_W'(hz);
    end else if (full) begin
      out_d.status = ST_FULL;
    end else begin
      out_d.status       = ST_OK;
      out_d.is_new       = 1'b1;
      out_d.vertex_index = new_idx[INDEX_W-1:0];
      out_d.vert_x       = COORD_W'(nx);
      out_d.vert_y       = COORD_W'(ny);
      out_d.vert_z       = COORD_W'(nz);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      thr_q       <= THR_RESET;
      clr_q       <= '0;
      init_q      <= 1'b1;
      cur_q       <= '0;
      cnt_q       <= '0;
      base_q      <= '0;
      tot_q       <= '0;
      rd_idx_q    <= '0;
      v1_q        <= 1'b0;
      reap_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_last ? '0 : clr_q + SW'(1);
        if (clr_last) begin
          init_q <= 1'b0;
        end
      end
      v1_q <= rd_en;
      if (rd_en) begin
        rd_idx_q <= rd_idx_q + OCW'(1);
      end
      if (state_q == S_CHECK) begin
        rd_idx_q <= '0;
        hit_q    <= 1'b0;
        reap_q   <= chk_reap;
        if (first_q) begin
          cur_q  <= id_q;
          cnt_q  <= '0;
          base_q <= '0;
          tot_q  <= '0;
        end else if (id_q != cur_q && !id_seen) begin
          cur_q  <= id_q;
          cnt_q  <= '0;
          base_q <= tot_q;
        end
      end
      if (state_q == S_SCAN && d_hit) begin
        hit_q <= 1'b1;
      end
      if (wr_en) begin
        cnt_q <= cnt_q + OCW'(1);
        tot_q <= tot_q + TW'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q <= corner_i.data.first_corner;
      id_q    <= corner_i.data.object_id;
      cx_q    <= corner_i.data.pos_x[CW-1:0];
      cy_q    <= corner_i.data.pos_y[CW-1:0];
      cz_q    <= corner_i.data.pos_z[CW-1:0];
    end
    idx1_q <= rd_idx_q;
    if (state_q == S_SCAN && d_hit) begin
      hit_idx_q  <= d_idx;
      hit_vert_q <= d_vert;
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OCW'(MAX_OBJECT_VERTICES))
    else $error("object vertex count beyond table depth");

  a_total_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    IXW'(tot_q) == IXW'(base_q) + IXW'(cnt_q))
    else $error("total count differs from base plus object count");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && d_hit) |-> (d_idx < cnt_q))
    else $error("match reported beyond stored vertices");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result beat raised outside final step");

  a_no_write_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (!reap_q && !hit_q && state_q == S_FINISH))
    else $error("vertex written on error or match");

endmodule

/* rtl/core/povw_dist.sv */
// Distance pipeline of the vertex weld block: abs difference, square, sum and
// threshold compare for one stored vertex per cycle. Depends on povw_pkg.
module povw_dist import povw_pkg::*; #(
  parameter int unsigned CW = 24,
  parameter int unsigned IW = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              flush_i,
  input  logic              in_valid_i,
  input  logic [IW-1:0]     in_idx_i,
  input  logic [3*CW-1:0]   vert_i,
  input  logic [3*CW-1:0]   corner_i,
  input  logic [THR_W-1:0]  thr_i,
  output logic              hit_o,
  output logic [IW-1:0]     hit_idx_o,
  output logic [3*CW-1:0]   hit_vert_o,
  output logic              busy_o
);

  logic              valid_a_q, valid_b_q;
  logic [IW-1:0]     idx_a_q, idx_b_q;
  logic [3*CW-1:0]   vert_a_q, vert_b_q;
  logic [CW-1:0]     ad_d [3];
  logic [CW-1:0]     ad_q [3];
  logic [2*CW-1:0]   sq_q [3];
  logic [2*CW+1:0]   sum;
  logic [THR_W-1:0]  sum_ext;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [CW:0] va, ca, df;
      va = $signed({vert_i[(3-k)*CW-1], vert_i[(3-k)*CW-1 -: CW]});
      ca = $signed({corner_i[(3-k)*CW-1], corner_i[(3-k)*CW-1 -: CW]});
      df = va - ca;
      ad_d[k] = df[CW] ? CW'(-df) : df[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (flush_i) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= in_valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_a_q  <= in_idx_i;
    vert_a_q <= vert_i;
    idx_b_q  <= idx_a_q;
    vert_b_q <= vert_a_q;
    for (int k = 0; k < 3; k++) begin
      ad_q[k] <= ad_d[k];
      sq_q[k] <= (2*CW)'(ad_q[k]) * (2*CW)'(ad_q[k]);
    end
  end

  assign sum        = (2*CW+2)'(sq_q[0]) + (2*CW+2)'(sq_q[1]) + (2*CW+2)'(sq_q[2]);
  assign sum_ext    = THR_W'(sum);
  assign hit_o      = valid_b_q && (sum_ext <= thr_i);
  assign hit_idx_o  = idx_b_q;
  assign hit_vert_o = vert_b_q;
  assign busy_o     = valid_a_q || valid_b_q;

endmodule
